>>> design/btot_pkg.sv
`timescale 1ns / 1ps
package btot_pkg;
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;
endpackage

>>> design/btot_cross_sign.sv
`timescale 1ns / 1ps
// sign of a*b - c*d: registered products, then combinational difference and sign
module btot_cross_sign
  import btot_pkg::*;
#(
  parameter int W = 18
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] c,
  input  logic signed [W-1:0] d,
  output sgn_t                sgn
);
  logic signed [2*W-1:0] p_r, q_r;
  logic signed [2*W:0]   diff;

  assign diff = {p_r[2*W-1], p_r} - {q_r[2*W-1], q_r};
  assign sgn.neg  = diff[2*W];
  assign sgn.zero = (diff == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
      q_r <= c * d;
    end
  end
endmodule

>>> design/box_triangle_overlap_test_core.sv
`timescale 1ns / 1ps
// Box / triangle overlap test. Each transfer carries one box and one triangle and
// produces one result transfer with box_inside (all four corners inside or on the
// triangle, zero cross product counts as inside) and edges_cross (some triangle edge
// crosses some box edge by the four-orientation test). Fully pipelined: one item per
// cycle unless stalled; registers in order: input, coordinate differences, multipliers,
// subtract plus sign combine into the output register. A stall freezes the whole pipe.
module box_triangle_overlap_test_core
  import btot_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_box_left,
  input  logic signed [COORD_WIDTH-1:0] in_box_bottom,
  input  logic        [COORD_WIDTH-2:0] in_box_width,
  input  logic        [COORD_WIDTH-2:0] in_box_height,
  input  logic signed [COORD_WIDTH-1:0] in_vertex0_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex0_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex1_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex1_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex2_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex2_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_box_inside,
  output logic                          out_edges_cross
);
  // corners need one extra bit, differences of corners one more
  localparam int PW = COORD_WIDTH + 1;
  localparam int DW = COORD_WIDTH + 2;
  // 12 corner tests + 48 orientation tests
  localparam int NC = 12;
  localparam int NO = 48;
  localparam int NS = NC + NO;

  // whole pipe moves unless the output is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: register points
  logic [3:0] v_r;
  logic signed [PW-1:0] tx_r [3];
  logic signed [PW-1:0] ty_r [3];
  logic signed [PW-1:0] bx_r [4];
  logic signed [PW-1:0] by_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  logic signed [PW-1:0] lft, bot, rgt, tp;
  assign lft = PW'(in_box_left);
  assign bot = PW'(in_box_bottom);
  assign rgt = lft + PW'({1'b0, in_box_width});
  assign tp  = bot + PW'({1'b0, in_box_height});

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r[0] <= PW'(in_vertex0_x); ty_r[0] <= PW'(in_vertex0_y);
      tx_r[1] <= PW'(in_vertex1_x); ty_r[1] <= PW'(in_vertex1_y);
      tx_r[2] <= PW'(in_vertex2_x); ty_r[2] <= PW'(in_vertex2_y);
      bx_r[0] <= lft; by_r[0] <= bot;
      bx_r[1] <= rgt; by_r[1] <= bot;
      bx_r[2] <= rgt; by_r[2] <= tp;
      bx_r[3] <= lft; by_r[3] <= tp;
    end
  end

  // stage 2: operand differences for every a*b - c*d
  logic signed [DW-1:0] oa_nxt [NS];
  logic signed [DW-1:0] ob_nxt [NS];
  logic signed [DW-1:0] oc_nxt [NS];
  logic signed [DW-1:0] od_nxt [NS];
  logic signed [DW-1:0] oa_r [NS];
  logic signed [DW-1:0] ob_r [NS];
  logic signed [DW-1:0] oc_r [NS];
  logic signed [DW-1:0] od_r [NS];

  function automatic logic signed [DW-1:0] df(logic signed [PW-1:0] x,
                                              logic signed [PW-1:0] y);
    return DW'(x) - DW'(y);
  endfunction

  always_comb begin
    // corner j against edge k: (p-c) x (q-c) with q=tri[k], c=tri[k+1]
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        oa_nxt[j*3+k] = df(bx_r[j], tx_r[(k+1)%3]);
        ob_nxt[j*3+k] = df(ty_r[k], ty_r[(k+1)%3]);
        oc_nxt[j*3+k] = df(tx_r[k], tx_r[(k+1)%3]);
        od_nxt[j*3+k] = df(by_r[j], ty_r[(k+1)%3]);
      end
    end
    // segment pair (i,j): o1..o4
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        // p1=tri[i] q1=tri[i+1] p2=box[j] q2=box[j+1]
        // orient(p,q,r) = (q.y-p.y)(r.x-q.x) - (q.x-p.x)(r.y-q.y)
        oa_nxt[NC+(i*4+j)*4+0] = df(ty_r[(i+1)%3], ty_r[i]);
        ob_nxt[NC+(i*4+j)*4+0] = df(bx_r[j], tx_r[(i+1)%3]);
        oc_nxt[NC+(i*4+j)*4+0] = df(tx_r[(i+1)%3], tx_r[i]);
        od_nxt[NC+(i*4+j)*4+0] = df(by_r[j], ty_r[(i+1)%3]);
        oa_nxt[NC+(i*4+j)*4+1] = df(ty_r[(i+1)%3], ty_r[i]);
        ob_nxt[NC+(i*4+j)*4+1] = df(bx_r[(j+1)%4], tx_r[(i+1)%3]);
        oc_nxt[NC+(i*4+j)*4+1] = df(tx_r[(i+1)%3], tx_r[i]);
        od_nxt[NC+(i*4+j)*4+1] = df(by_r[(j+1)%4], ty_r[(i+1)%3]);
        oa_nxt[NC+(i*4+j)*4+2] = df(by_r[(j+1)%4], by_r[j]);
        ob_nxt[NC+(i*4+j)*4+2] = df(tx_r[i], bx_r[(j+1)%4]);
        oc_nxt[NC+(i*4+j)*4+2] = df(bx_r[(j+1)%4], bx_r[j]);
        od_nxt[NC+(i*4+j)*4+2] = df(ty_r[i], by_r[(j+1)%4]);
        oa_nxt[NC+(i*4+j)*4+3] = df(by_r[(j+1)%4], by_r[j]);
        ob_nxt[NC+(i*4+j)*4+3] = df(tx_r[(i+1)%3], bx_r[(j+1)%4]);
        oc_nxt[NC+(i*4+j)*4+3] = df(bx_r[(j+1)%4], bx_r[j]);
        od_nxt[NC+(i*4+j)*4+3] = df(ty_r[(i+1)%3], by_r[(j+1)%4]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oa_r <= oa_nxt;
      ob_r <= ob_nxt;
      oc_r <= oc_nxt;
      od_r <= od_nxt;
    end
  end

  // stage 3: products (inside the sign units), then difference and sign
  sgn_t sg [NS];
  for (genvar g = 0; g < NS; g++) begin : g_cs
    btot_cross_sign #(.W(DW)) u_cs (
      .clk (clk),
      .en  (adv),
      .a   (oa_r[g]),
      .b   (ob_r[g]),
      .c   (oc_r[g]),
      .d   (od_r[g]),
      .sgn (sg[g])
    );
  end

  // stage 4: combine signs into the output register
  logic inside_nxt, cross_nxt;
  logic inside_r, cross_r;
  always_comb begin
    logic ng, ps;
    logic [1:0] o1, o2, o3, o4;
    inside_nxt = 1'b1;
    cross_nxt  = 1'b0;
    for (int j = 0; j < 4; j++) begin
      ng = 1'b0;
      ps = 1'b0;
      for (int k = 0; k < 3; k++) begin
        ng = ng | sg[j*3+k].neg;
        ps = ps | (!sg[j*3+k].neg && !sg[j*3+k].zero);
      end
      if (ng && ps) inside_nxt = 1'b0;
    end
    for (int p = 0; p < 12; p++) begin
      o1 = {sg[NC+p*4+0].neg, sg[NC+p*4+0].zero};
      o2 = {sg[NC+p*4+1].neg, sg[NC+p*4+1].zero};
      o3 = {sg[NC+p*4+2].neg, sg[NC+p*4+2].zero};
      o4 = {sg[NC+p*4+3].neg, sg[NC+p*4+3].zero};
      if (o1 != o2 && o3 != o4) cross_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= inside_nxt;
      cross_r  <= cross_nxt;
    end
  end

  assign out_valid       = v_r[3];
  assign out_box_inside  = inside_r;
  assign out_edges_cross = cross_r;

  // a held result keeps its flags
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_box_inside) &&
      $stable(out_edges_cross))
    else $error("held result changed");
  // an accepted item reaches the output when the pipe is not stalled meanwhile
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
    else $error("item lost in pipe");
  // input stall mirrors the held output
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("stall without pending result");
endmodule
